[hw/rtl/jov_pkg.sv]
// Shared types, codes and character helpers for the JSON object validator.
package jov_pkg;

	typedef enum logic [4:0] {
		M_TOP_PRE     = 5'd0,
		M_OBJ_FIRST   = 5'd1,
		M_OBJ_KEY     = 5'd2,
		M_AFTER_KEY   = 5'd3,
		M_VALUE       = 5'd4,
		M_ARR_FIRST   = 5'd5,
		M_ARR_NEXT    = 5'd6,
		M_AFTER_VALUE = 5'd7,
		M_TOP_POST    = 5'd8,
		M_KSTR        = 5'd9,
		M_KESC        = 5'd10,
		M_KHEX        = 5'd11,
		M_VSTR        = 5'd12,
		M_VESC        = 5'd13,
		M_VHEX        = 5'd14,
		M_LIT         = 5'd15,
		M_N_MINUS     = 5'd16,
		M_N_ZERO      = 5'd17,
		M_N_INT       = 5'd18,
		M_N_DOT       = 5'd19,
		M_N_FRAC      = 5'd20,
		M_N_E         = 5'd21,
		M_N_ESIGN     = 5'd22,
		M_N_EXP       = 5'd23
	} mode_t;

	localparam logic KIND_OBJ = 1'b0;
	localparam logic KIND_ARR = 1'b1;

	localparam logic [1:0] WORD_TRUE  = 2'd0;
	localparam logic [1:0] WORD_FALSE = 2'd1;
	localparam logic [1:0] WORD_NULL  = 2'd2;

	// Stack command from the parser to the nesting stack.
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
		logic kind;
	} stack_op_t;

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
			((b >= 8'h41) && (b <= 8'h46));
	endfunction

	function automatic logic [2:0] word_len(input logic [1:0] kind);
		return (kind == WORD_FALSE) ? 3'd5 : 3'd4;
	endfunction

	// Expected character of a literal at a position; zero where none exists.
	function automatic logic [7:0] word_char(input logic [1:0] kind, input logic [2:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (kind)
			WORD_TRUE: begin
				case (pos)
					3'd0: c = 8'h74;
					3'd1: c = 8'h72;
					3'd2: c = 8'h75;
					3'd3: c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			WORD_FALSE: begin
				case (pos)
					3'd0: c = 8'h66;
					3'd1: c = 8'h61;
					3'd2: c = 8'h6C;
					3'd3: c = 8'h73;
					3'd4: c = 8'h65;
					default: c = 8'h00;
				endcase
			end
			WORD_NULL: begin
				case (pos)
					3'd0: c = 8'h6E;
					3'd1: c = 8'h75;
					3'd2: c = 8'h6C;
					3'd3: c = 8'h6C;
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[hw/rtl/jov_stack.sv]
// Nesting stack: kind of each open container, top and next-to-top held in registers.
module jov_stack #(
	parameter int MAX_DEPTH = 512
) (
	input  logic               clk,
	input  logic               arst_n,
	input  jov_pkg::stack_op_t op,
	output logic               top_kind,
	output logic [$clog2(MAX_DEPTH+2)-1:0] depth
);
	localparam int CW = $clog2(MAX_DEPTH + 2);
	localparam int AW = (MAX_DEPTH + 1 > 1) ? $clog2(MAX_DEPTH + 1) : 1;
	localparam int Entries = 1 << AW;

	logic          mem [0:Entries-1];
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] rd_ptr;
	logic          top_q;
	logic          under_q;

	always_comb begin
		if (op.clear) begin
			count_d = '0;
		end else if (op.push) begin
			count_d = count_q + CW'(1);
		end else if (op.pop) begin
			count_d = count_q - CW'(1);
		end else begin
			count_d = count_q;
		end
		rd_ptr = count_d - CW'(2);
	end

	// under_q always follows the entry below the top for the coming cycle
	always_ff @(posedge clk) begin
		if (op.push) begin
			mem[count_q[AW-1:0]] <= op.kind;
		end
		under_q <= mem[rd_ptr[AW-1:0]];
		if (op.push) begin
			top_q <= op.kind;
		end else if (op.pop) begin
			top_q <= under_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign top_kind = top_q;
	assign depth    = count_q;

endmodule

[hw/rtl/json_object_validator_core.sv]
// Top level of the streaming strict-JSON object validator.
//
// Input channel: text_valid / text_stall carry text_byte and end_of_doc,
// one document byte per transfer; end_of_doc marks the last byte.
// Output channel: verdict_valid / verdict_stall carry doc_ok, one transfer
// per document, 1 when the document is exactly one valid JSON object
// surrounded only by whitespace.
// Throughput: one byte per cycle while text_stall is low. Each byte is
// parsed by the mode FSM in the cycle it is taken; the nesting stack
// keeps its top and the entry below it in registers, so a push or pop
// never waits on the stack RAM. Latency: the verdict is registered and
// appears the cycle after the last byte's transfer.
// Errors are sticky: later bytes of the same document are ignored.
// After the last byte all parser state returns to its start values.
// Reset: arst_n clears the parser, stack depth and verdict_valid, not doc_ok.
// No clearing pass is needed; stack entries are only read after being
// pushed in the current document.
// Stall: while a verdict waits under verdict_stall, text_stall is raised;
// otherwise bytes keep flowing as the verdict is taken.
module json_object_validator_core #(
	parameter int MAX_DEPTH = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_stall,
	input  logic [7:0] text_byte,
	input  logic       end_of_doc,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output logic       doc_ok
);
	localparam int CW = $clog2(MAX_DEPTH + 2);
	localparam logic [CW-1:0] MaxLvl = CW'(MAX_DEPTH);

	jov_pkg::mode_t     mode_q, mode_d;
	logic [2:0]         hex_q, hex_d;
	logic [2:0]         wpos_q, wpos_d;
	logic [1:0]         wkind_q, wkind_d;
	logic               failed_q, fail_d;
	logic               verdict_valid_q;
	logic               doc_ok_q;
	jov_pkg::stack_op_t sop;
	logic               top_kind;
	logic [CW-1:0]      depth;
	logic               acc;
	logic               av;
	logic               bv;
	logic               cl;
	logic               cl_kind;
	logic               push;
	logic               pop;
	logic               pkind;

	assign text_stall = verdict_valid_q & verdict_stall;
	assign acc        = text_valid & ~text_stall;

	always_comb begin
		mode_d  = mode_q;
		hex_d   = hex_q;
		wpos_d  = wpos_q;
		wkind_d = wkind_q;
		fail_d  = failed_q;
		av      = 1'b0;
		bv      = 1'b0;
		cl      = 1'b0;
		cl_kind = jov_pkg::KIND_OBJ;
		push    = 1'b0;
		pop     = 1'b0;
		pkind   = jov_pkg::KIND_OBJ;

		unique case (mode_q)
			jov_pkg::M_TOP_PRE: begin
				if (text_byte == "{") begin
					push   = 1'b1;
					pkind  = jov_pkg::KIND_OBJ;
					mode_d = jov_pkg::M_OBJ_FIRST;
				end else if (!jov_pkg::is_ws(text_byte)) begin
					fail_d = 1'b1;
				end
			end
			jov_pkg::M_OBJ_FIRST: begin
				if (text_byte == "\"") begin
					mode_d = jov_pkg::M_KSTR;
				end else if (text_byte == "}") begin
					cl = 1'b1; cl_kind = jov_pkg::KIND_OBJ;
				end else if (!jov_pkg::is_ws(text_byte)) begin
					fail_d = 1'b1;
				end
			end
			jov_pkg::M_OBJ_KEY: begin
				if (text_byte == "\"") begin
					mode_d = jov_pkg::M_KSTR;
				end else if (!jov_pkg::is_ws(text_byte)) begin
					fail_d = 1'b1;
				end
			end
			jov_pkg::M_AFTER_KEY: begin
				if (text_byte == ":") begin
					mode_d = jov_pkg::M_VALUE;
				end else if (!jov_pkg::is_ws(text_byte)) begin
					fail_d = 1'b1;
				end
			end
			jov_pkg::M_VALUE, jov_pkg::M_ARR_NEXT: begin
				bv = !jov_pkg::is_ws(text_byte);
			end
			jov_pkg::M_ARR_FIRST: begin
				if (text_byte == "]") begin
					cl = 1'b1; cl_kind = jov_pkg::KIND_ARR;
				end else begin
					bv = !jov_pkg::is_ws(text_byte);
				end
			end
			jov_pkg::M_AFTER_VALUE: av = 1'b1;
			jov_pkg::M_TOP_POST: begin
				if (!jov_pkg::is_ws(text_byte)) fail_d = 1'b1;
			end
			jov_pkg::M_KSTR, jov_pkg::M_VSTR: begin
				if (text_byte == "\"") begin
					mode_d = (mode_q == jov_pkg::M_KSTR) ? jov_pkg::M_AFTER_KEY
						: jov_pkg::M_AFTER_VALUE;
				end else if (text_byte < 8'h20) begin
					fail_d = 1'b1;
				end else if (text_byte == "\\") begin
					mode_d = (mode_q == jov_pkg::M_KSTR) ? jov_pkg::M_KESC
						: jov_pkg::M_VESC;
				end
			end
			jov_pkg::M_KESC, jov_pkg::M_VESC: begin
				if (text_byte == "\"" || text_byte == "\\" || text_byte == "/" ||
					text_byte == "b" || text_byte == "f" || text_byte == "n" ||
					text_byte == "r" || text_byte == "t") begin
					mode_d = (mode_q == jov_pkg::M_KESC) ? jov_pkg::M_KSTR
						: jov_pkg::M_VSTR;
				end else if (text_byte == "u") begin
					hex_d  = 3'd4;
					mode_d = (mode_q == jov_pkg::M_KESC) ? jov_pkg::M_KHEX
						: jov_pkg::M_VHEX;
				end else begin
					fail_d = 1'b1;
				end
			end
			jov_pkg::M_KHEX, jov_pkg::M_VHEX: begin
				if (!jov_pkg::is_hex(text_byte) || hex_q == 3'd0) begin
					fail_d = 1'b1;
				end else begin
					hex_d = hex_q - 3'd1;
					if (hex_q == 3'd1) begin
						mode_d = (mode_q == jov_pkg::M_KHEX) ? jov_pkg::M_KSTR
							: jov_pkg::M_VSTR;
					end
				end
			end
			jov_pkg::M_LIT: begin
				if (wkind_q > jov_pkg::WORD_NULL || wpos_q >= jov_pkg::word_len(wkind_q) ||
					jov_pkg::word_char(wkind_q, wpos_q) != text_byte) begin
					fail_d = 1'b1;
				end else begin
					wpos_d = wpos_q + 3'd1;
					if (wpos_q + 3'd1 == jov_pkg::word_len(wkind_q)) begin
						mode_d = jov_pkg::M_AFTER_VALUE;
					end
				end
			end
			jov_pkg::M_N_MINUS: begin
				if (text_byte == "0") mode_d = jov_pkg::M_N_ZERO;
				else if (text_byte >= "1" && text_byte <= "9") mode_d = jov_pkg::M_N_INT;
				else fail_d = 1'b1;
			end
			jov_pkg::M_N_ZERO, jov_pkg::M_N_INT: begin
				if (jov_pkg::is_digit(text_byte)) begin
					if (mode_q == jov_pkg::M_N_ZERO) fail_d = 1'b1;
				end else if (text_byte == ".") begin
					mode_d = jov_pkg::M_N_DOT;
				end else if (text_byte == "e" || text_byte == "E") begin
					mode_d = jov_pkg::M_N_E;
				end else begin
					mode_d = jov_pkg::M_AFTER_VALUE; av = 1'b1;
				end
			end
			jov_pkg::M_N_DOT: begin
				if (jov_pkg::is_digit(text_byte)) mode_d = jov_pkg::M_N_FRAC;
				else fail_d = 1'b1;
			end
			jov_pkg::M_N_FRAC: begin
				if (jov_pkg::is_digit(text_byte)) begin
					mode_d = mode_q;
				end else if (text_byte == "e" || text_byte == "E") begin
					mode_d = jov_pkg::M_N_E;
				end else begin
					mode_d = jov_pkg::M_AFTER_VALUE; av = 1'b1;
				end
			end
			jov_pkg::M_N_E: begin
				if (text_byte == "+" || text_byte == "-") mode_d = jov_pkg::M_N_ESIGN;
				else if (jov_pkg::is_digit(text_byte)) mode_d = jov_pkg::M_N_EXP;
				else fail_d = 1'b1;
			end
			jov_pkg::M_N_ESIGN: begin
				if (jov_pkg::is_digit(text_byte)) mode_d = jov_pkg::M_N_EXP;
				else fail_d = 1'b1;
			end
			jov_pkg::M_N_EXP: begin
				if (!jov_pkg::is_digit(text_byte)) begin
					mode_d = jov_pkg::M_AFTER_VALUE; av = 1'b1;
				end
			end
			default: fail_d = 1'b1;
		endcase

		// start of a nested value
		if (bv) begin
			if (depth > MaxLvl) begin
				fail_d = 1'b1;
			end else if (text_byte == "{") begin
				push = 1'b1; pkind = jov_pkg::KIND_OBJ; mode_d = jov_pkg::M_OBJ_FIRST;
			end else if (text_byte == "[") begin
				push = 1'b1; pkind = jov_pkg::KIND_ARR; mode_d = jov_pkg::M_ARR_FIRST;
			end else if (text_byte == "\"") begin
				mode_d = jov_pkg::M_VSTR;
			end else if (text_byte == "t" || text_byte == "f" || text_byte == "n") begin
				wkind_d = (text_byte == "t") ? jov_pkg::WORD_TRUE
					: (text_byte == "f") ? jov_pkg::WORD_FALSE : jov_pkg::WORD_NULL;
				wpos_d  = 3'd1;
				mode_d  = jov_pkg::M_LIT;
			end else if (text_byte == "-") begin
				mode_d = jov_pkg::M_N_MINUS;
			end else if (text_byte == "0") begin
				mode_d = jov_pkg::M_N_ZERO;
			end else if (text_byte >= "1" && text_byte <= "9") begin
				mode_d = jov_pkg::M_N_INT;
			end else begin
				fail_d = 1'b1;
			end
		end

		// byte after a complete value
		if (av && !jov_pkg::is_ws(text_byte)) begin
			if (depth == '0) begin
				fail_d = 1'b1;
			end else if (text_byte == ",") begin
				mode_d = (top_kind == jov_pkg::KIND_OBJ) ? jov_pkg::M_OBJ_KEY
					: jov_pkg::M_ARR_NEXT;
			end else if (text_byte == "}") begin
				cl = 1'b1; cl_kind = jov_pkg::KIND_OBJ;
			end else if (text_byte == "]") begin
				cl = 1'b1; cl_kind = jov_pkg::KIND_ARR;
			end else begin
				fail_d = 1'b1;
			end
		end

		if (cl) begin
			if (depth == '0 || top_kind != cl_kind) begin
				fail_d = 1'b1;
			end else begin
				pop    = 1'b1;
				mode_d = (depth == CW'(1)) ? jov_pkg::M_TOP_POST : jov_pkg::M_AFTER_VALUE;
			end
		end
	end

	assign sop.push  = acc & ~failed_q & push;
	assign sop.pop   = acc & ~failed_q & pop;
	assign sop.clear = acc & end_of_doc;
	assign sop.kind  = pkind;

	jov_stack #(
		.MAX_DEPTH(MAX_DEPTH)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (sop),
		.top_kind(top_kind),
		.depth   (depth)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= jov_pkg::M_TOP_PRE;
			hex_q    <= '0;
			wpos_q   <= '0;
			wkind_q  <= '0;
			failed_q <= 1'b0;
		end else if (acc) begin
			if (end_of_doc) begin
				mode_q   <= jov_pkg::M_TOP_PRE;
				hex_q    <= '0;
				wpos_q   <= '0;
				wkind_q  <= '0;
				failed_q <= 1'b0;
			end else if (!failed_q) begin
				mode_q   <= mode_d;
				hex_q    <= hex_d;
				wpos_q   <= wpos_d;
				wkind_q  <= wkind_d;
				failed_q <= fail_d;
			end
		end
	end

	// verdict register; a waiting verdict drains before a new one loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (acc && end_of_doc) begin
			verdict_valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && end_of_doc) begin
			doc_ok_q <= ~failed_q & ~fail_d & (mode_d == jov_pkg::M_TOP_POST);
		end
	end

	assign verdict_valid = verdict_valid_q;
	assign doc_ok        = doc_ok_q;

endmodule
